// ===== src/assert_macros.svh =====
// assertion macros shared by the deque rtl
// no dependencies; expects clk and rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define BID_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// plain invariant on the current cycle
`define BID_INVARIANT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

// ===== src/bid_pkg.sv =====
// types and codes for the bounded indexed deque
// no dependencies
package bid_pkg;

  // action codes
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_REMOVE     = 3'd2;
  localparam logic [2:0] ACT_READ       = 3'd3;
  localparam logic [2:0] ACT_WRITE      = 3'd4;

  // status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  // control states
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHIFT
  } state_t;

  // one request
  typedef struct packed {
    logic [2:0]         action;
    logic [5:0]         position;
    logic signed [31:0] data_in;
  } req_t;

  // one response
  typedef struct packed {
    logic signed [31:0] data_out;
    logic [6:0]         count;
    logic [1:0]         status;
  } rsp_t;

endpackage

// ===== src/bounded_indexed_deque_top.sv =====
// bounded indexed deque: circular element memory with read-modify-write control
// depends on bid_pkg and assert_macros.svh
`include "assert_macros.svh"

// Ordered list of signed 32-bit values, up to CAPACITY entries, kept in one
// synchronous memory (one write port, one read port, registered read data).
// Requests: assert start with in_req while busy is low; the request is taken
// at that clock edge. Each request gives exactly one response on out_rsp,
// shown for one cycle with out_strobe high; the receiver cannot hold it off.
// From accept edge to out_strobe:
//   push front, push back, write, refused or unknown requests: the response
//   is registered at the accept edge; read at index: one memory read, then
//   the response is registered from S_READ; remove at index p: registered at
//   the accept edge if p is the last element, else at the end of S_SHIFT,
//   where the shift loop moves one element per cycle through the memory,
//   writing element k+1 into slot k while reading element k+2.
// busy is high in the read and shift states, so a request can be taken every
// cycle for requests that enter neither S_READ nor S_SHIFT, and a remove of
// the front of a full list keeps busy high until every later element has moved.
// Reset (rst_n low, synchronous) empties the list and returns the front
// slot to zero; memory contents are left as they are and are never read
// before being written. A new request may be taken while the previous
// response is still on the output register.
module bounded_indexed_deque_top #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  bid_pkg::req_t in_req,
  output logic          out_strobe,
  output bid_pkg::rsp_t out_rsp
);

  localparam int SW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;
  localparam logic [SW:0]   CAP_S = (SW + 1)'(CAPACITY);
  localparam logic [CMPW-1:0] CAP_C = CMPW'(CAPACITY);

  // element memory
  logic [31:0] mem [CAPACITY];
  logic [31:0] rd_data_r;

  logic          mem_rd_en;
  logic [SW-1:0] mem_rd_addr;
  logic          mem_wr_en;
  logic [SW-1:0] mem_wr_addr;
  logic [31:0]   mem_wr_data;

  bid_pkg::state_t state_r, state_nxt;
  logic [SW-1:0]   front_r, front_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [SW-1:0]   wr_idx_r, wr_idx_nxt;
  logic            out_strobe_r, out_strobe_nxt;
  bid_pkg::rsp_t   out_rsp_r, out_rsp_nxt;

  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] count_ext;
  logic [CMPW-1:0] next_rd_ext;
  logic            in_range;
  logic            rm_last;
  logic            full;
  logic            shift_more;

  // store slot of list element k, wrapping around the circular store
  function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] front,
                                            input logic [SW-1:0] k);
    logic [SW:0] sum;
    sum = {1'b0, front} + {1'b0, k};
    if (sum >= CAP_S) begin
      sum = sum - CAP_S;
    end
    return sum[SW-1:0];
  endfunction

  // request decode
  assign pos_ext     = CMPW'(in_req.position);
  assign count_ext   = CMPW'(count_r);
  assign in_range    = pos_ext < count_ext;
  assign rm_last     = (pos_ext + CMPW'(1)) == count_ext;
  assign full        = count_ext >= CAP_C;
  assign next_rd_ext = CMPW'(wr_idx_r) + CMPW'(2);
  assign shift_more  = next_rd_ext < count_ext;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bid_pkg::S_IDLE: begin
        if (start && in_range) begin
          if (in_req.action == bid_pkg::ACT_READ) begin
            state_nxt = bid_pkg::S_READ;
          end else if (in_req.action == bid_pkg::ACT_REMOVE && !rm_last) begin
            state_nxt = bid_pkg::S_SHIFT;
          end
        end
      end
      bid_pkg::S_READ: begin
        state_nxt = bid_pkg::S_IDLE;
      end
      bid_pkg::S_SHIFT: begin
        if (!shift_more) begin
          state_nxt = bid_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bid_pkg::S_IDLE;
      end
    endcase
  end

  // datapath, memory controls and response
  always_comb begin
    mem_rd_en      = 1'b0;
    mem_rd_addr    = '0;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = '0;
    mem_wr_data    = '0;
    front_nxt      = front_r;
    count_nxt      = count_r;
    wr_idx_nxt     = wr_idx_r;
    out_strobe_nxt = 1'b0;
    out_rsp_nxt    = '0;
    case (state_r)
      bid_pkg::S_IDLE: begin
        if (start) begin
          out_strobe_nxt = 1'b1;
          case (in_req.action)
            bid_pkg::ACT_PUSH_FRONT: begin
              if (full) begin
                out_rsp_nxt.status = bid_pkg::STAT_FULL;
              end else begin
                front_nxt   = (front_r == '0) ? SW'(CAPACITY - 1) : front_r - SW'(1);
                mem_wr_en   = 1'b1;
                mem_wr_addr = front_nxt;
                mem_wr_data = in_req.data_in;
                count_nxt   = count_r + CW'(1);
              end
            end
            bid_pkg::ACT_PUSH_BACK: begin
              if (full) begin
                out_rsp_nxt.status = bid_pkg::STAT_FULL;
              end else begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = slot_of(front_r, count_ext[SW-1:0]);
                mem_wr_data = in_req.data_in;
                count_nxt   = count_r + CW'(1);
              end
            end
            bid_pkg::ACT_REMOVE: begin
              if (!in_range) begin
                out_rsp_nxt.status = bid_pkg::STAT_RANGE;
              end else if (rm_last) begin
                count_nxt = count_r - CW'(1);
                if (count_r == CW'(1)) begin
                  front_nxt = '0;
                end
              end else begin
                // start the shift: fetch the element behind the gap
                out_strobe_nxt = 1'b0;
                mem_rd_en      = 1'b1;
                mem_rd_addr    = slot_of(front_r, pos_ext[SW-1:0] + SW'(1));
                wr_idx_nxt     = pos_ext[SW-1:0];
              end
            end
            bid_pkg::ACT_READ: begin
              if (!in_range) begin
                out_rsp_nxt.status = bid_pkg::STAT_RANGE;
              end else begin
                out_strobe_nxt = 1'b0;
                mem_rd_en      = 1'b1;
                mem_rd_addr    = slot_of(front_r, pos_ext[SW-1:0]);
              end
            end
            bid_pkg::ACT_WRITE: begin
              if (!in_range) begin
                out_rsp_nxt.status = bid_pkg::STAT_RANGE;
              end else begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = slot_of(front_r, pos_ext[SW-1:0]);
                mem_wr_data = in_req.data_in;
              end
            end
            default: begin
            end
          endcase
        end
      end
      bid_pkg::S_READ: begin
        out_strobe_nxt       = 1'b1;
        out_rsp_nxt.data_out = rd_data_r;
      end
      bid_pkg::S_SHIFT: begin
        // move element k+1 into slot of k, prefetch element k+2
        mem_wr_en   = 1'b1;
        mem_wr_addr = slot_of(front_r, wr_idx_r);
        mem_wr_data = rd_data_r;
        if (shift_more) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = slot_of(front_r, next_rd_ext[SW-1:0]);
          wr_idx_nxt  = wr_idx_r + SW'(1);
        end else begin
          count_nxt      = count_r - CW'(1);
          out_strobe_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
    out_rsp_nxt.count = 7'(count_nxt);
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
  end

  // memory read port, registered data
  always_ff @(posedge clk) begin
    if (mem_rd_en) begin
      rd_data_r <= mem[mem_rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bid_pkg::S_IDLE;
      front_r      <= '0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      front_r      <= front_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    wr_idx_r  <= wr_idx_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  assign busy       = (state_r != bid_pkg::S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

  // terms used by the checks
  logic one_cycle_req;
  logic rsp_refused;
  logic in_shift;
  logic in_read;

  assign one_cycle_req = start && !busy &&
                         (in_req.action == bid_pkg::ACT_PUSH_FRONT ||
                          in_req.action == bid_pkg::ACT_PUSH_BACK ||
                          in_req.action == bid_pkg::ACT_WRITE);
  assign rsp_refused   = out_strobe && (out_rsp.status != bid_pkg::STAT_DONE);
  assign in_shift      = (state_r == bid_pkg::S_SHIFT);
  assign in_read       = (state_r == bid_pkg::S_READ);

  // checks
  `BID_INVARIANT(a_count_bound, count_ext <= CAP_C, "element count above capacity")
  `BID_ASSERT(a_refused_zero, rsp_refused |-> out_rsp.data_out == '0, "refused request data")
  `BID_ASSERT(a_single_cycle, one_cycle_req |=> out_strobe, "single-cycle request late")
  `BID_ASSERT(a_shift_index, in_shift |-> next_rd_ext <= count_ext, "shift past end of list")
  `BID_ASSERT(a_read_resp, in_read |=> out_strobe && !busy, "read response late")

endmodule
